[hdl/btl_pkg.sv]
// Shared types, codes and character constants for the bracket token lexer.
package btl_pkg;

  typedef enum logic [3:0] {
    ST_EMPTY      = 4'd0,
    ST_FUNC_IN    = 4'd1,
    ST_FUNC_DONE  = 4'd2,
    ST_CONST_IN   = 4'd3,
    ST_CONST_DONE = 4'd4,
    ST_ESC_OPEN   = 4'd5,
    ST_ESC_CLOSE  = 4'd6,
    ST_VAR_OPEN   = 4'd7,
    ST_USE_IN     = 4'd8,
    ST_USE_DONE   = 4'd9,
    ST_BIND_IN    = 4'd10,
    ST_BIND_BANG  = 4'd11,
    ST_BIND_DONE  = 4'd12
  } lex_state_t;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_FUNC  = 3'd1,
    KIND_CONST = 3'd2,
    KIND_USE   = 3'd3,
    KIND_BIND  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ERR_OK      = 3'd0,
    ERR_OPENER  = 3'd1,
    ERR_FUNC    = 3'd2,
    ERR_CONST   = 3'd3,
    ERR_ESCAPE  = 3'd4,
    ERR_VAR     = 3'd5,
    ERR_DONE    = 3'd6
  } err_t;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;

  typedef struct packed {
    lex_state_t st;
    logic [7:0] open_char;
    logic [7:0] close_char;
  } lex_ctx_t;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] out_char;
    logic       started;
    logic       done_res;
    kind_t      token_kind;
    err_t       error_code;
  } lex_res_t;

  localparam lex_ctx_t CTX_RESET = '{st: ST_EMPTY, open_char: 8'h00, close_char: 8'h00};

endpackage

[hdl/btl_if.sv]
// Valid/ready channel interfaces for the lexer input and result streams.
interface btl_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] letter;

  modport source (output valid, output mode, output letter, input ready);
  modport sink (input valid, input mode, input letter, output ready);
endinterface

interface btl_out_if;
  logic       valid;
  logic       ready;
  logic       char_valid;
  logic [7:0] out_char;
  logic       started;
  logic       done_res;
  logic [2:0] token_kind;
  logic [2:0] error_code;

  modport source (output valid, output char_valid, output out_char, output started,
                  output done_res, output token_kind, output error_code, input ready);
  modport sink (input valid, input char_valid, input out_char, input started,
                input done_res, input token_kind, input error_code, output ready);
endinterface

[hdl/btl_step.sv]
// Combinational lexer step: next context and result for one character.
module btl_step (
  input  btl_pkg::lex_ctx_t ctx,
  input  logic              mode,
  input  logic [7:0]        letter,
  output btl_pkg::lex_ctx_t ctx_nxt,
  output btl_pkg::lex_res_t res
);

  btl_pkg::lex_ctx_t nc;
  btl_pkg::err_t     err;
  logic              emit;
  logic [7:0]        ch;
  logic              is_open;
  logic              is_close;
  logic              is_curly;

  assign is_open  = (letter == ctx.open_char);
  assign is_close = (letter == ctx.close_char);
  assign is_curly = (letter == btl_pkg::CH_LBRACE) || (letter == btl_pkg::CH_RBRACE);

  always_comb begin
    nc   = ctx;
    err  = btl_pkg::ERR_OK;
    emit = 1'b0;
    ch   = letter;
    case (ctx.st)
      btl_pkg::ST_EMPTY: begin
        case (letter)
          btl_pkg::CH_LBRACE: nc = '{btl_pkg::ST_FUNC_IN, btl_pkg::CH_LBRACE, btl_pkg::CH_RBRACE};
          btl_pkg::CH_RBRACE: nc = '{btl_pkg::ST_FUNC_IN, btl_pkg::CH_RBRACE, btl_pkg::CH_LBRACE};
          btl_pkg::CH_LBRACK: nc = '{btl_pkg::ST_CONST_IN, btl_pkg::CH_LBRACK, btl_pkg::CH_RBRACK};
          btl_pkg::CH_RBRACK: nc = '{btl_pkg::ST_CONST_IN, btl_pkg::CH_RBRACK, btl_pkg::CH_LBRACK};
          btl_pkg::CH_LPAREN: nc = '{btl_pkg::ST_VAR_OPEN, btl_pkg::CH_LPAREN, btl_pkg::CH_RPAREN};
          btl_pkg::CH_RPAREN: nc = '{btl_pkg::ST_VAR_OPEN, btl_pkg::CH_RPAREN, btl_pkg::CH_LPAREN};
          default: err = btl_pkg::ERR_OPENER;
        endcase
      end
      btl_pkg::ST_FUNC_IN: begin
        if (letter == btl_pkg::CH_QUOTE || is_open || letter == btl_pkg::CH_BANG ||
            letter == btl_pkg::CH_LPAREN || letter == btl_pkg::CH_RPAREN) begin
          err = btl_pkg::ERR_FUNC;
        end else if (is_close) begin
          nc.st = btl_pkg::ST_FUNC_DONE;
        end else begin
          emit = 1'b1;
        end
      end
      btl_pkg::ST_CONST_IN: begin
        if (letter == btl_pkg::CH_BSLASH) begin
          nc.st = btl_pkg::ST_ESC_OPEN;
        end else if (is_open) begin
          err = btl_pkg::ERR_CONST;
        end else if (is_close) begin
          nc.st = btl_pkg::ST_CONST_DONE;
        end else begin
          emit = 1'b1;
        end
      end
      btl_pkg::ST_ESC_OPEN: begin
        if (letter == btl_pkg::CH_BSLASH) begin
          nc.st = btl_pkg::ST_CONST_IN;
          emit  = 1'b1;
        end else if (letter == btl_pkg::CH_N) begin
          nc.st = btl_pkg::ST_ESC_CLOSE;
          emit  = 1'b1;
          ch    = btl_pkg::CH_LF;
        end else if (letter == btl_pkg::CH_T) begin
          nc.st = btl_pkg::ST_ESC_CLOSE;
          emit  = 1'b1;
          ch    = btl_pkg::CH_TAB;
        end else if (letter == btl_pkg::CH_LBRACK || letter == btl_pkg::CH_RBRACK) begin
          nc.st = btl_pkg::ST_ESC_CLOSE;
          emit  = 1'b1;
        end else begin
          err = btl_pkg::ERR_ESCAPE;
        end
      end
      btl_pkg::ST_ESC_CLOSE: begin
        if (letter == btl_pkg::CH_BSLASH) begin
          nc.st = btl_pkg::ST_CONST_IN;
        end else begin
          err = btl_pkg::ERR_ESCAPE;
        end
      end
      btl_pkg::ST_VAR_OPEN: begin
        if (is_open || is_curly || letter == btl_pkg::CH_QUOTE) begin
          err = btl_pkg::ERR_VAR;
        end else if (is_close) begin
          nc.st = btl_pkg::ST_USE_DONE;
        end else if (letter == btl_pkg::CH_BANG) begin
          nc.st = btl_pkg::ST_BIND_IN;
        end else begin
          nc.st = btl_pkg::ST_USE_IN;
          emit  = 1'b1;
        end
      end
      btl_pkg::ST_USE_IN: begin
        if (is_open || letter == btl_pkg::CH_BANG || is_curly ||
            letter == btl_pkg::CH_QUOTE) begin
          err = btl_pkg::ERR_VAR;
        end else if (is_close) begin
          nc.st = btl_pkg::ST_USE_DONE;
        end else begin
          emit = 1'b1;
        end
      end
      btl_pkg::ST_BIND_IN: begin
        if (is_open || is_close || is_curly || letter == btl_pkg::CH_QUOTE) begin
          err = btl_pkg::ERR_VAR;
        end else if (letter == btl_pkg::CH_BANG) begin
          nc.st = btl_pkg::ST_BIND_BANG;
        end else begin
          emit = 1'b1;
        end
      end
      btl_pkg::ST_BIND_BANG: begin
        if (is_close) begin
          nc.st = btl_pkg::ST_BIND_DONE;
        end else begin
          err = btl_pkg::ERR_VAR;
        end
      end
      btl_pkg::ST_FUNC_DONE, btl_pkg::ST_CONST_DONE,
      btl_pkg::ST_USE_DONE, btl_pkg::ST_BIND_DONE: begin
        err = btl_pkg::ERR_DONE;
      end
      default: begin
        err = btl_pkg::ERR_OPENER;
      end
    endcase
    if (err != btl_pkg::ERR_OK) begin
      nc   = ctx;
      emit = 1'b0;
    end

    ctx_nxt = mode ? btl_pkg::CTX_RESET : nc;

    res.char_valid = emit && !mode;
    res.out_char   = res.char_valid ? ch : 8'h00;
    res.error_code = mode ? btl_pkg::ERR_OK : err;
    res.started    = (ctx_nxt.st != btl_pkg::ST_EMPTY);
    res.done_res   = (ctx_nxt.st == btl_pkg::ST_FUNC_DONE) ||
                     (ctx_nxt.st == btl_pkg::ST_CONST_DONE) ||
                     (ctx_nxt.st == btl_pkg::ST_USE_DONE) ||
                     (ctx_nxt.st == btl_pkg::ST_BIND_DONE);
    case (ctx_nxt.st)
      btl_pkg::ST_FUNC_IN, btl_pkg::ST_FUNC_DONE: res.token_kind = btl_pkg::KIND_FUNC;
      btl_pkg::ST_CONST_IN, btl_pkg::ST_CONST_DONE,
      btl_pkg::ST_ESC_OPEN, btl_pkg::ST_ESC_CLOSE: res.token_kind = btl_pkg::KIND_CONST;
      btl_pkg::ST_VAR_OPEN, btl_pkg::ST_USE_IN,
      btl_pkg::ST_USE_DONE: res.token_kind = btl_pkg::KIND_USE;
      btl_pkg::ST_BIND_IN, btl_pkg::ST_BIND_BANG,
      btl_pkg::ST_BIND_DONE: res.token_kind = btl_pkg::KIND_BIND;
      default: res.token_kind = btl_pkg::KIND_NONE;
    endcase
  end

endmodule

[hdl/bracket_token_lexer.sv]
// Top level of the bracket token lexer: context register and result register.
// A result is registered and appears on the output channel in the cycle after its input transfer.
// Throughput: one character per cycle; the single result register refills in the
// same cycle it is drained, so the input stalls only while a result waits.
// Reset: synchronous active-low rst_n returns the lexer to the empty state with
// both bracket characters zero and the result register empty.
module bracket_token_lexer (
  input  logic      clk,
  input  logic      rst_n,
  btl_in_if.sink    in_ch,
  btl_out_if.source out_ch
);

  btl_pkg::lex_ctx_t ctx_r;
  btl_pkg::lex_ctx_t ctx_nxt;
  btl_pkg::lex_res_t res_nxt;
  btl_pkg::lex_res_t res_r;
  logic              out_valid_r;
  logic              in_xfer;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  btl_step u_step (
    .ctx     (ctx_r),
    .mode    (in_ch.mode),
    .letter  (in_ch.letter),
    .ctx_nxt (ctx_nxt),
    .res     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r       <= btl_pkg::CTX_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        ctx_r <= ctx_nxt;
      end
      if (in_ch.ready) begin
        out_valid_r <= in_ch.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.char_valid = res_r.char_valid;
  assign out_ch.out_char   = res_r.out_char;
  assign out_ch.started    = res_r.started;
  assign out_ch.done_res   = res_r.done_res;
  assign out_ch.token_kind = res_r.token_kind;
  assign out_ch.error_code = res_r.error_code;

endmodule

[hdl/btl_checker.sv]
// Port-level checker for the bracket token lexer and its bind.
module btl_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_mode,
  input logic       out_valid,
  input logic       out_ready,
  input logic       char_valid,
  input logic [7:0] out_char,
  input logic       started,
  input logic       done_res,
  input logic [2:0] token_kind,
  input logic [2:0] error_code
);

  a_emit_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && char_valid |-> error_code == btl_pkg::ERR_OK)
    else $error("character emitted together with an error");

  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !char_valid |-> out_char == 8'h00)
    else $error("out_char nonzero without char_valid");

  a_done_started: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && done_res |-> started && token_kind != btl_pkg::KIND_NONE)
    else $error("done reported without a started token");

  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode |=> out_valid && !char_valid && !started &&
      !done_res && token_kind == btl_pkg::KIND_NONE && error_code == btl_pkg::ERR_OK)
    else $error("clear did not produce an all-zero result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

endmodule

bind bracket_token_lexer btl_checker u_btl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_mode    (in_ch.mode),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .char_valid (out_ch.char_valid),
  .out_char   (out_ch.out_char),
  .started    (out_ch.started),
  .done_res   (out_ch.done_res),
  .token_kind (out_ch.token_kind),
  .error_code (out_ch.error_code)
);

[dv/btl_result_check.sv]
// Result checker for the bracket token lexer: predicts each result and compares it.
module btl_result_check (
  input  logic clk,
  input  logic rst_n,
  btl_in_if    in_ch,
  btl_out_if   out_ch,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  btl_pkg::lex_ctx_t lex_ctx = btl_pkg::CTX_RESET;
  btl_pkg::lex_res_t predicted_results[$];
  btl_pkg::lex_res_t want;

  function automatic btl_pkg::lex_res_t lex_predict(input logic clr, input logic [7:0] c);
    btl_pkg::lex_res_t   r;
    btl_pkg::lex_state_t nxt;
    btl_pkg::err_t       e;
    logic [7:0]          cl;
    r = '0;
    nxt = lex_ctx.st;
    e = btl_pkg::ERR_OK;
    cl = 8'h00;
    if (clr) begin
      lex_ctx = btl_pkg::CTX_RESET;
      return r;
    end
    case (lex_ctx.st)
      btl_pkg::ST_EMPTY: begin
        case (c)
          btl_pkg::CH_LBRACE: begin nxt = btl_pkg::ST_FUNC_IN;  cl = btl_pkg::CH_RBRACE; end
          btl_pkg::CH_RBRACE: begin nxt = btl_pkg::ST_FUNC_IN;  cl = btl_pkg::CH_LBRACE; end
          btl_pkg::CH_LBRACK: begin nxt = btl_pkg::ST_CONST_IN; cl = btl_pkg::CH_RBRACK; end
          btl_pkg::CH_RBRACK: begin nxt = btl_pkg::ST_CONST_IN; cl = btl_pkg::CH_LBRACK; end
          btl_pkg::CH_LPAREN: begin nxt = btl_pkg::ST_VAR_OPEN; cl = btl_pkg::CH_RPAREN; end
          btl_pkg::CH_RPAREN: begin nxt = btl_pkg::ST_VAR_OPEN; cl = btl_pkg::CH_LPAREN; end
          default: e = btl_pkg::ERR_OPENER;
        endcase
        if (e == btl_pkg::ERR_OK) begin
          lex_ctx.open_char = c;
          lex_ctx.close_char = cl;
        end
      end
      btl_pkg::ST_FUNC_IN: begin
        if (c == btl_pkg::CH_QUOTE || c == lex_ctx.open_char || c == btl_pkg::CH_BANG ||
            c == btl_pkg::CH_LPAREN || c == btl_pkg::CH_RPAREN) e = btl_pkg::ERR_FUNC;
        else if (c == lex_ctx.close_char) nxt = btl_pkg::ST_FUNC_DONE;
        else begin r.char_valid = 1'b1; r.out_char = c; end
      end
      btl_pkg::ST_CONST_IN: begin
        if (c == btl_pkg::CH_BSLASH) nxt = btl_pkg::ST_ESC_OPEN;
        else if (c == lex_ctx.open_char) e = btl_pkg::ERR_CONST;
        else if (c == lex_ctx.close_char) nxt = btl_pkg::ST_CONST_DONE;
        else begin r.char_valid = 1'b1; r.out_char = c; end
      end
      btl_pkg::ST_ESC_OPEN: begin
        if (c == btl_pkg::CH_BSLASH) begin
          nxt = btl_pkg::ST_CONST_IN; r.char_valid = 1'b1; r.out_char = btl_pkg::CH_BSLASH;
        end else if (c == btl_pkg::CH_N) begin
          nxt = btl_pkg::ST_ESC_CLOSE; r.char_valid = 1'b1; r.out_char = btl_pkg::CH_LF;
        end else if (c == btl_pkg::CH_T) begin
          nxt = btl_pkg::ST_ESC_CLOSE; r.char_valid = 1'b1; r.out_char = btl_pkg::CH_TAB;
        end else if (c == btl_pkg::CH_LBRACK || c == btl_pkg::CH_RBRACK) begin
          nxt = btl_pkg::ST_ESC_CLOSE; r.char_valid = 1'b1; r.out_char = c;
        end else e = btl_pkg::ERR_ESCAPE;
      end
      btl_pkg::ST_ESC_CLOSE: begin
        if (c == btl_pkg::CH_BSLASH) nxt = btl_pkg::ST_CONST_IN;
        else e = btl_pkg::ERR_ESCAPE;
      end
      btl_pkg::ST_VAR_OPEN: begin
        if (c == lex_ctx.open_char || c == btl_pkg::CH_LBRACE || c == btl_pkg::CH_RBRACE ||
            c == btl_pkg::CH_QUOTE)
          e = btl_pkg::ERR_VAR;
        else if (c == lex_ctx.close_char) nxt = btl_pkg::ST_USE_DONE;
        else if (c == btl_pkg::CH_BANG) nxt = btl_pkg::ST_BIND_IN;
        else begin nxt = btl_pkg::ST_USE_IN; r.char_valid = 1'b1; r.out_char = c; end
      end
      btl_pkg::ST_USE_IN: begin
        if (c == lex_ctx.open_char || c == btl_pkg::CH_BANG || c == btl_pkg::CH_LBRACE ||
            c == btl_pkg::CH_RBRACE || c == btl_pkg::CH_QUOTE) e = btl_pkg::ERR_VAR;
        else if (c == lex_ctx.close_char) nxt = btl_pkg::ST_USE_DONE;
        else begin r.char_valid = 1'b1; r.out_char = c; end
      end
      btl_pkg::ST_BIND_IN: begin
        if (c == lex_ctx.open_char || c == lex_ctx.close_char || c == btl_pkg::CH_LBRACE ||
            c == btl_pkg::CH_RBRACE || c == btl_pkg::CH_QUOTE) e = btl_pkg::ERR_VAR;
        else if (c == btl_pkg::CH_BANG) nxt = btl_pkg::ST_BIND_BANG;
        else begin r.char_valid = 1'b1; r.out_char = c; end
      end
      btl_pkg::ST_BIND_BANG: begin
        if (c == lex_ctx.close_char) nxt = btl_pkg::ST_BIND_DONE;
        else e = btl_pkg::ERR_VAR;
      end
      btl_pkg::ST_FUNC_DONE, btl_pkg::ST_CONST_DONE,
      btl_pkg::ST_USE_DONE, btl_pkg::ST_BIND_DONE: e = btl_pkg::ERR_DONE;
      default: e = btl_pkg::ERR_OPENER;
    endcase
    if (e == btl_pkg::ERR_OK) lex_ctx.st = nxt;
    r.error_code = e;
    r.started = (lex_ctx.st != btl_pkg::ST_EMPTY);
    r.done_res = (lex_ctx.st == btl_pkg::ST_FUNC_DONE || lex_ctx.st == btl_pkg::ST_CONST_DONE ||
                  lex_ctx.st == btl_pkg::ST_USE_DONE || lex_ctx.st == btl_pkg::ST_BIND_DONE);
    case (lex_ctx.st)
      btl_pkg::ST_FUNC_IN, btl_pkg::ST_FUNC_DONE: r.token_kind = btl_pkg::KIND_FUNC;
      btl_pkg::ST_CONST_IN, btl_pkg::ST_CONST_DONE,
      btl_pkg::ST_ESC_OPEN, btl_pkg::ST_ESC_CLOSE: r.token_kind = btl_pkg::KIND_CONST;
      btl_pkg::ST_VAR_OPEN, btl_pkg::ST_USE_IN,
      btl_pkg::ST_USE_DONE: r.token_kind = btl_pkg::KIND_USE;
      btl_pkg::ST_BIND_IN, btl_pkg::ST_BIND_BANG,
      btl_pkg::ST_BIND_DONE: r.token_kind = btl_pkg::KIND_BIND;
      default: r.token_kind = btl_pkg::KIND_NONE;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got 0x%0h, predicted 0x%0h", name, got, exp_val));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      lex_ctx = btl_pkg::CTX_RESET;
      predicted_results.delete();
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("result transfer with no prediction pending");
        end else begin
          want = predicted_results.pop_front();
          check_field("char_valid", 8'(out_ch.char_valid), 8'(want.char_valid));
          check_field("out_char", out_ch.out_char, want.out_char);
          check_field("started", 8'(out_ch.started), 8'(want.started));
          check_field("done_res", 8'(out_ch.done_res), 8'(want.done_res));
          check_field("token_kind", 8'(out_ch.token_kind), 8'(want.token_kind));
          check_field("error_code", 8'(out_ch.error_code), 8'(want.error_code));
        end
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        predicted_results.insert(predicted_results.size(),
                                 lex_predict(in_ch.mode, in_ch.letter));
    end
    outstanding = predicted_results.size();
  end

endmodule

[dv/tb.sv]
// Top of the bracket token lexer testbench: clock, reset, stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] BRACKETS [6] = '{
    btl_pkg::CH_LBRACE, btl_pkg::CH_RBRACE, btl_pkg::CH_LBRACK, btl_pkg::CH_RBRACK,
    btl_pkg::CH_LPAREN, btl_pkg::CH_RPAREN
  };
  localparam logic [7:0] ODD_CHARS [13] = '{
    btl_pkg::CH_LBRACE, btl_pkg::CH_RBRACE, btl_pkg::CH_LBRACK, btl_pkg::CH_RBRACK,
    btl_pkg::CH_LPAREN, btl_pkg::CH_RPAREN, btl_pkg::CH_BANG, btl_pkg::CH_BSLASH,
    btl_pkg::CH_QUOTE, btl_pkg::CH_N, btl_pkg::CH_T, 8'h00, 8'hFF
  };
  localparam logic [7:0] ESC_CHARS [5] = '{
    btl_pkg::CH_BSLASH, btl_pkg::CH_N, btl_pkg::CH_T, btl_pkg::CH_LBRACK, btl_pkg::CH_RBRACK
  };
  localparam logic [8:0] DIRECTED [24] = '{
    {1'b1, 8'h00}, {1'b0, 8'h00}, {1'b0, btl_pkg::CH_LBRACK},
    {1'b0, btl_pkg::CH_BSLASH}, {1'b0, btl_pkg::CH_BSLASH}, {1'b0, btl_pkg::CH_BSLASH},
    {1'b0, btl_pkg::CH_N}, {1'b0, 8'h78}, {1'b0, btl_pkg::CH_BSLASH},
    {1'b0, 8'hFF}, {1'b0, btl_pkg::CH_RBRACK}, {1'b0, 8'h61},
    {1'b1, 8'hFF}, {1'b0, btl_pkg::CH_RPAREN}, {1'b0, btl_pkg::CH_BANG},
    {1'b0, 8'h71}, {1'b0, btl_pkg::CH_BANG}, {1'b0, btl_pkg::CH_LPAREN},
    {1'b1, 8'h5A}, {1'b0, btl_pkg::CH_RBRACE}, {1'b0, btl_pkg::CH_QUOTE},
    {1'b0, btl_pkg::CH_LBRACE}, {1'b1, 8'hA5}, {1'b0, 8'hFF}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   in_idle_pct = 38;
  int   out_idle_pct = 55;
  int   sent = 0;
  int   mismatches;
  int   outstanding;

  btl_in_if  in_ch ();
  btl_out_if out_ch ();

  bracket_token_lexer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  btl_result_check u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  function automatic logic [7:0] body_char();
    if ($urandom_range(9) < 2) return ODD_CHARS[$urandom_range(12)];
    return 8'($urandom_range(255));
  endfunction

  task automatic send_item(input logic m, input logic [7:0] c);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.mode <= 1'($urandom_range(1));
      in_ch.letter <= 8'($urandom_range(255));
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= m;
    in_ch.letter <= c;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_escape();
    int         pick;
    logic [7:0] e;
    pick = $urandom_range(5);
    e = (pick == 5) ? 8'($urandom_range(255)) : ESC_CHARS[pick];
    send_item(1'b0, btl_pkg::CH_BSLASH);
    send_item(1'b0, e);
    if (e != btl_pkg::CH_BSLASH && $urandom_range(9) != 0) send_item(1'b0, btl_pkg::CH_BSLASH);
  endtask

  task automatic send_token();
    int   idx;
    int   len;
    logic is_bind;
    idx = $urandom_range(5);
    is_bind = (idx >= 4) && ($urandom_range(1) == 1);
    len = $urandom_range(6);
    send_item(1'b0, BRACKETS[idx]);
    if (is_bind) send_item(1'b0, btl_pkg::CH_BANG);
    repeat (len) begin
      if (idx / 2 == 1 && $urandom_range(3) == 0) send_escape();
      else send_item(1'b0, body_char());
    end
    if (is_bind) send_item(1'b0, btl_pkg::CH_BANG);
    send_item(1'b0, BRACKETS[idx ^ 1]);
    if ($urandom_range(7) == 0) send_item(1'b0, body_char());
  endtask

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int r;
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.letter = 8'h00;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 3; ph++) begin
      in_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 55 : 0;
      out_idle_pct = (ph == 0) ? 55 : (ph == 1) ? 38 : 0;
      if (ph == 0) begin
        foreach (DIRECTED[i]) send_item(DIRECTED[i][8], DIRECTED[i][7:0]);
      end
      while (sent < (ph + 1) * 170) begin
        r = $urandom_range(99);
        if (r < 85) begin
          if ($urandom_range(9) != 0) send_item(1'b1, 8'($urandom_range(255)));
          send_token();
        end else if (r < 93) begin
          send_item(1'b0, body_char());
        end else begin
          send_item(1'b1, 8'($urandom_range(255)));
        end
      end
    end
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
